// ===== rtl/tdpt_pkg.sv =====
// types shared by the trial division prime test block
// controller state, datapath commands and datapath status
`timescale 1ns / 1ps

package tdpt_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_EVAL,
    S_OUT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the candidate, divisor back to two
    logic start_div;  // begin a remainder pass for the current divisor
    logic step;       // one restoring division bit
    logic next_d;     // advance the divisor by one
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic below_two;  // candidate below two
    logic last_bit;   // this step is the final division bit
    logic rem_zero;   // remainder of the finished pass is zero
    logic d_gt_q;     // divisor exceeds the quotient, search is over
  } sts_t;

  localparam int unsigned OUT_TDATA_W = 8;

endpackage

// ===== rtl/tdpt_dpath.sv =====
// datapath: candidate, divisor and a bit-serial restoring divider
// depends on tdpt_pkg for the command and status structs
`timescale 1ns / 1ps

module tdpt_dpath #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic [NUMBER_WIDTH-1:0] candidate,
  input  tdpt_pkg::cmd_t          cmd,
  output tdpt_pkg::sts_t          sts
);

  localparam int unsigned CW = (NUMBER_WIDTH > 2) ? $clog2(NUMBER_WIDTH) : 1;

  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [NUMBER_WIDTH-1:0] d_r, d_nxt;
  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] quo_r, quo_nxt;   // dividend shifts out, quotient shifts in
  logic [CW-1:0]           cnt_r, cnt_nxt;

  logic [NUMBER_WIDTH:0]   rem_shift;
  logic [NUMBER_WIDTH:0]   rem_diff;
  logic                    q_bit;

  assign rem_shift = {rem_r, quo_r[NUMBER_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, d_r};
  assign q_bit     = (rem_shift >= {1'b0, d_r});

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      n_nxt = candidate;
      d_nxt = NUMBER_WIDTH'(2);
    end
    if (cmd.next_d) begin
      d_nxt = d_r + NUMBER_WIDTH'(1);
    end
    if (cmd.start_div) begin
      rem_nxt = '0;
      quo_nxt = n_r;
      cnt_nxt = CW'(NUMBER_WIDTH - 1);
    end else if (cmd.step) begin
      // a kept remainder is below the divisor, so it fits the low bits
      rem_nxt = q_bit ? rem_diff[NUMBER_WIDTH-1:0] : rem_shift[NUMBER_WIDTH-1:0];
      quo_nxt = {quo_r[NUMBER_WIDTH-2:0], q_bit};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.below_two = (n_r[NUMBER_WIDTH-1:1] == '0);
  assign sts.last_bit  = (cnt_r == '0);
  assign sts.rem_zero  = (rem_r == '0);
  assign sts.d_gt_q    = (d_r > quo_r);

endmodule

// ===== rtl/tdpt_ctrl.sv =====
// controller: sequences the divisor search and holds the result register
// depends on tdpt_pkg for the state type and the command and status structs
`timescale 1ns / 1ps

module tdpt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic           out_is_prime,
  output tdpt_pkg::cmd_t cmd,
  input  tdpt_pkg::sts_t sts
);

  tdpt_pkg::state_t state_r, state_nxt;
  logic verdict_r, verdict_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic out_is_prime_r, out_is_prime_nxt;
  logic out_free;

  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    case (state_r)
      tdpt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = tdpt_pkg::S_TEST;
      end
      tdpt_pkg::S_TEST: begin
        if (sts.below_two) begin
          verdict_nxt = 1'b0;
          state_nxt   = tdpt_pkg::S_OUT;
        end else begin
          state_nxt = tdpt_pkg::S_DIV;
        end
      end
      tdpt_pkg::S_DIV: begin
        if (sts.last_bit) state_nxt = tdpt_pkg::S_EVAL;
      end
      tdpt_pkg::S_EVAL: begin
        if (sts.d_gt_q) begin
          verdict_nxt = 1'b1;
          state_nxt   = tdpt_pkg::S_OUT;
        end else if (sts.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = tdpt_pkg::S_OUT;
        end else begin
          state_nxt = tdpt_pkg::S_DIV;
        end
      end
      tdpt_pkg::S_OUT: begin
        if (out_free) state_nxt = tdpt_pkg::S_IDLE;
      end
      default: state_nxt = tdpt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd              = '0;
    in_tready        = 1'b0;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_is_prime_nxt = out_is_prime_r;
    case (state_r)
      tdpt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      tdpt_pkg::S_TEST: begin
        cmd.start_div = !sts.below_two;
      end
      tdpt_pkg::S_DIV: begin
        cmd.step = 1'b1;
      end
      tdpt_pkg::S_EVAL: begin
        // no divisor hit yet: try the next one
        if (!sts.d_gt_q && !sts.rem_zero) begin
          cmd.next_d    = 1'b1;
          cmd.start_div = 1'b1;
        end
      end
      tdpt_pkg::S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt   = 1'b1;
          out_is_prime_nxt = verdict_r;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tdpt_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r      <= verdict_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// one candidate word at a time; a word below two goes from the test state straight to the
// output state, otherwise the bit-serial divider runs a full remainder pass per divisor
// tried, from two upward, until a divisor divides the word or exceeds its quotient
// the next word is taken once the result is in the output register
// synchronous active-low reset returns the controller to idle and empties the output
`timescale 1ns / 1ps

module trial_division_prime_test #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     in_tdata,   // candidate
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0]      out_tdata   // is_prime
);

  tdpt_pkg::cmd_t cmd;
  tdpt_pkg::sts_t sts;
  logic           is_prime;

  tdpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_is_prime (is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  tdpt_dpath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .candidate (in_tdata[NUMBER_WIDTH-1:0]),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign out_tdata = {{(tdpt_pkg::OUT_TDATA_W-1){1'b0}}, is_prime};

endmodule

// ===== rtl/tdpt_checker.sv =====
// port-level checks for the trial division prime test block, bound to the top level
// depends on trial_division_prime_test and tdpt_pkg
`timescale 1ns / 1ps

module tdpt_checker #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((NUMBER_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tdpt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // reset leaves the block idle with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("block not idle after reset");

  // one word in flight: no new word the cycle after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken twice in a row");

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

  // result word carries only the verdict bit
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[tdpt_pkg::OUT_TDATA_W-1:1] == '0))
    else $error("result padding not zero");

endmodule

bind trial_division_prime_test tdpt_checker #(
  .NUMBER_WIDTH (NUMBER_WIDTH)
) u_tdpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/trial_division_prime_test_tb.sv =====
// testbench for trial_division_prime_test: feeds candidate words and checks each
// is_prime word against a trial-division predictor in a small scoreboard
// depends on rtl/tdpt_pkg.sv and rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

  localparam int unsigned NW          = 32;
  localparam int unsigned IN_W        = ((NW + 7) / 8) * 8;
  localparam int unsigned N_RANDOM    = 68;
  localparam int unsigned TRIAL_CAP   = 256;      // keeps random words cheap
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 600000;   // outlasts the slowest directed word

  class prime_scoreboard;
    bit          verdict_q[$];
    int unsigned n_errors;

    function bit trial_divide(input logic [NW-1:0] n, output int unsigned tries);
      longint unsigned num;
      longint unsigned d;
      tries = 0;
      num = n;
      if (num < 2) return 1'b0;
      for (d = 2; d <= num / d; d++) begin
        tries++;
        if (num % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(input logic [IN_W-1:0] word);
      int unsigned tries;
      verdict_q.push_back(trial_divide(word[NW-1:0], tries));
    endfunction

    function void check_verdict(input logic [tdpt_pkg::OUT_TDATA_W-1:0] word);
      bit want;
      if (verdict_q.size() == 0) begin
        $error("is_prime: no result expected, got %0b", word[0]);
        n_errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (word[0] !== want) begin
        $error("is_prime mismatch: expected %0b, got %0b", want, word[0]);
        n_errors++;
      end
      if (word[tdpt_pkg::OUT_TDATA_W-1:1] !== '0) begin
        $error("out_tdata padding mismatch: expected 0, got %0h",
               word[tdpt_pkg::OUT_TDATA_W-1:1]);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [IN_W-1:0]                    in_tdata;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [tdpt_pkg::OUT_TDATA_W-1:0]   out_tdata;

  prime_scoreboard sb;
  bit              quiet;
  bit              long_hold_req;
  int unsigned     idle_cycles;

  trial_division_prime_test #(
    .NUMBER_WIDTH(NW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_candidate(input logic [IN_W-1:0] cand);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cand;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_candidate(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL trial_division_prime_test");
    $finish;
  end

  initial begin : result_sink
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !quiet) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        if (!quiet) repeat ($urandom_range(0, 29)) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [IN_W-1:0] directed_set [$];
    logic [IN_W-1:0] cand;
    int unsigned     tries;
    int unsigned     i;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    idle_cycles   = 0;
    sb = new();
    // zero and one, smallest primes, squares of primes right at the divisor bound,
    // all-ones and top-bit words, and one square that walks 4092 divisors
    directed_set = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
                     32'd97, 32'd121, 32'd63001, 32'd64507, 32'd65537,
                     32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'd16752649};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_set[k]) send_candidate(directed_set[k]);

    // sink holds off while cheap words keep coming, so the input backs up
    long_hold_req = 1'b1;
    repeat (12) send_candidate($urandom_range(0, 255));

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
      if (i == N_RANDOM - 15) quiet = 1'b1;
      case ($urandom_range(0, 3))
        0:       cand = $urandom_range(0, 4095);
        1:       cand = $urandom_range(0, 65535);
        2:       cand = $urandom & 32'h000F_FFFF;
        default: cand = $urandom;
      endcase
      // a word needing too many divisors is made even, so it fails at two
      void'(sb.trial_divide(cand[NW-1:0], tries));
      if (tries > TRIAL_CAP) cand[0] = 1'b0;
      send_candidate(cand);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS trial_division_prime_test");
    end else begin
      $display("FAIL trial_division_prime_test");
    end
    $finish;
  end

endmodule
